// ----- hdl/ftsw_pkg.sv -----
// shared constants, types and codes of the flat triangle span walker
package ftsw_pkg;

   localparam int SCREEN_ROWS = 64;
   localparam int COORD_BITS  = 10;
   localparam int FRAC_BITS   = 16;

   localparam int ACC_BITS  = COORD_BITS + FRAC_BITS + 2;
   localparam int ROW_BITS  = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
   localparam int ROWC_BITS = ((COORD_BITS > ROW_BITS) ? COORD_BITS : ROW_BITS) + 2;
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int MAG_BITS  = COORD_BITS;
   localparam int NUM_BITS  = MAG_BITS + FRAC_BITS;
   localparam int CNT_BITS  = $clog2(NUM_BITS + 1);
   localparam int SPAN_BITS = ACC_BITS - FRAC_BITS;

   localparam int REQ_DATA_BITS = ((6 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((ROW_BITS + 2 * COORD_BITS + 7) / 8) * 8;

   localparam int FIFO_DEPTH     = 2;
   localparam int FIFO_PTR_BITS  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FIFO_CNT_BITS  = $clog2(FIFO_DEPTH + 1);

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [ACC_BITS-1:0]   acc_type;
   typedef logic signed [ROWC_BITS-1:0]  row_type;

   localparam acc_type ACC_MAX  = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam acc_type ACC_MIN  = {1'b1, {(ACC_BITS-1){1'b0}}};
   localparam row_type ROW_ZERO = '0;
   localparam row_type ROW_ONE  = ROWC_BITS'(1);
   localparam row_type ROW_LAST = ROWC_BITS'(SCREEN_ROWS - 1);

   typedef enum logic {
      DIR_UP   = 1'b0,
      DIR_DOWN = 1'b1
   } dir_type;

   // one walk job handed from the front end to the span walker
   typedef struct packed {
      dir_type   dir;
      coord_type start_x_a;
      coord_type start_x_b;
      row_type   start_row;
      row_type   end_row;
      acc_type   slope_a;
      acc_type   slope_b;
   } job_type;

   typedef struct packed {
      logic dx_neg;
      logic dx_zero;
      logic dy_neg;
      logic dy_zero;
   } edge_flags_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_DIVIDE,
      FRONT_PUSH
   } front_state_type;

   typedef enum logic {
      WALK_IDLE,
      WALK_RUN
   } walk_state_type;

endpackage

// ----- hdl/ftsw_div.sv -----
// radix-2 restoring divider for unsigned slope magnitudes
module ftsw_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ftsw_pkg::NUM_BITS-1:0] dividend,
   input  logic [ftsw_pkg::MAG_BITS-1:0] divisor,
   output logic                          busy,
   output logic [ftsw_pkg::NUM_BITS-1:0] quotient
);
   import ftsw_pkg::*;

   logic [NUM_BITS-1:0] quo_ff, quo_in;
   logic [MAG_BITS-1:0] rem_ff, rem_in;
   logic [MAG_BITS-1:0] den_ff, den_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic [MAG_BITS:0]   trial;
   logic [MAG_BITS:0]   diff;
   logic                fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_BITS-1]};
      diff    = trial - {1'b0, den_ff};
      fits    = trial >= {1'b0, den_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = CNT_BITS'(NUM_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // one quotient bit a cycle, remainder stays below the divisor
         rem_in  = fits ? diff[MAG_BITS-1:0] : trial[MAG_BITS-1:0];
         quo_in  = {quo_ff[NUM_BITS-2:0], fits};
         cnt_in  = cnt_ff - CNT_BITS'(1);
         busy_in = (cnt_ff != CNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// ----- hdl/ftsw_front.sv -----
// front end: takes a triangle, works out both edge slopes and the row range
module ftsw_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [ftsw_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic                               req_tuser,
   output logic                               job_valid,
   input  logic                               job_ready,
   output ftsw_pkg::job_type                  job
);
   import ftsw_pkg::*;

   front_state_type state_ff, state_in;

   coord_type in_ax, in_ay, in_p2x, in_p2y, in_p3x, in_p3y;
   logic signed [DIFF_BITS-1:0] dx_a, dy_a, dx_b, dy_b;
   logic accept;

   dir_type        dir_ff, dir_in;
   coord_type      p2x_ff, p2x_in, p3x_ff, p3x_in;
   row_type        p2y_ff, p2y_in, ay_ff, ay_in;
   edge_flags_type flags_a_ff, flags_a_in, flags_b_ff, flags_b_in;

   logic                busy_a, busy_b;
   logic [NUM_BITS-1:0] quo_a, quo_b;

   logic    has_spans;
   row_type end_row;

   function automatic logic [MAG_BITS-1:0] diff_mag(logic signed [DIFF_BITS-1:0] d);
      logic signed [DIFF_BITS-1:0] m;
      m = d[DIFF_BITS-1] ? -d : d;
      return m[MAG_BITS-1:0];
   endfunction

   function automatic edge_flags_type diff_flags(logic signed [DIFF_BITS-1:0] dx,
                                                 logic signed [DIFF_BITS-1:0] dy);
      edge_flags_type f;
      f.dx_neg  = dx[DIFF_BITS-1];
      f.dx_zero = (dx == '0);
      f.dy_neg  = dy[DIFF_BITS-1];
      f.dy_zero = (dy == '0);
      return f;
   endfunction

   function automatic acc_type edge_slope(edge_flags_type f, logic [NUM_BITS-1:0] q);
      acc_type mag;
      acc_type res;
      mag = ACC_BITS'(q);
      if (f.dy_zero) begin
         // horizontal edge: largest magnitude with the sign of dx, zero when dx is zero
         res = f.dx_zero ? '0 : (f.dx_neg ? ACC_MIN : ACC_MAX);
      end else begin
         res = (f.dx_neg ^ f.dy_neg) ? -mag : mag;
      end
      return res;
   endfunction

   assign in_ax  = req_tdata[0*COORD_BITS +: COORD_BITS];
   assign in_ay  = req_tdata[1*COORD_BITS +: COORD_BITS];
   assign in_p2x = req_tdata[2*COORD_BITS +: COORD_BITS];
   assign in_p2y = req_tdata[3*COORD_BITS +: COORD_BITS];
   assign in_p3x = req_tdata[4*COORD_BITS +: COORD_BITS];
   assign in_p3y = req_tdata[5*COORD_BITS +: COORD_BITS];

   assign dx_a = {in_ax[COORD_BITS-1], in_ax} - {in_p2x[COORD_BITS-1], in_p2x};
   assign dy_a = {in_ay[COORD_BITS-1], in_ay} - {in_p2y[COORD_BITS-1], in_p2y};
   assign dx_b = {in_ax[COORD_BITS-1], in_ax} - {in_p3x[COORD_BITS-1], in_p3x};
   assign dy_b = {in_ay[COORD_BITS-1], in_ay} - {in_p3y[COORD_BITS-1], in_p3y};

   assign accept = req_tvalid && req_tready;

   ftsw_div u_div_a (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend ({diff_mag(dx_a), {FRAC_BITS{1'b0}}}),
      .divisor  (diff_mag(dy_a)),
      .busy     (busy_a),
      .quotient (quo_a)
   );

   ftsw_div u_div_b (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend ({diff_mag(dx_b), {FRAC_BITS{1'b0}}}),
      .divisor  (diff_mag(dy_b)),
      .busy     (busy_b),
      .quotient (quo_b)
   );

   // row range that lands on screen, and its last row
   always_comb begin
      if (dir_ff == DIR_DOWN) begin
         has_spans = (p2y_ff > ay_ff) && (p2y_ff >= ROW_ZERO) && (ay_ff < ROW_LAST);
         end_row   = (ay_ff >= ROW_ZERO) ? ay_ff + ROW_ONE : ROW_ZERO;
      end else begin
         has_spans = (ay_ff > p2y_ff) && (p2y_ff <= ROW_LAST) && (ay_ff > ROW_ZERO);
         end_row   = (ay_ff <= ROW_LAST) ? ay_ff - ROW_ONE : ROW_LAST;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FRONT_IDLE:   if (req_tvalid) state_in = FRONT_DIVIDE;
         FRONT_DIVIDE: if (!busy_a && !busy_b) state_in = FRONT_PUSH;
         FRONT_PUSH:   if (!has_spans || job_ready) state_in = FRONT_IDLE;
         default:      state_in = FRONT_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == FRONT_IDLE);
      job_valid  = (state_ff == FRONT_PUSH) && has_spans;
   end

   always_comb begin
      dir_in     = dir_ff;
      p2x_in     = p2x_ff;
      p3x_in     = p3x_ff;
      p2y_in     = p2y_ff;
      ay_in      = ay_ff;
      flags_a_in = flags_a_ff;
      flags_b_in = flags_b_ff;
      if (accept) begin
         dir_in     = dir_type'(req_tuser);
         p2x_in     = in_p2x;
         p3x_in     = in_p3x;
         p2y_in     = {{(ROWC_BITS-COORD_BITS){in_p2y[COORD_BITS-1]}}, in_p2y};
         ay_in      = {{(ROWC_BITS-COORD_BITS){in_ay[COORD_BITS-1]}}, in_ay};
         flags_a_in = diff_flags(dx_a, dy_a);
         flags_b_in = diff_flags(dx_b, dy_b);
      end
   end

   always_comb begin
      job.dir       = dir_ff;
      job.start_x_a = p2x_ff;
      job.start_x_b = p3x_ff;
      job.start_row = p2y_ff;
      job.end_row   = end_row;
      job.slope_a   = edge_slope(flags_a_ff, quo_a);
      job.slope_b   = edge_slope(flags_b_ff, quo_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      dir_ff     <= dir_in;
      p2x_ff     <= p2x_in;
      p3x_ff     <= p3x_in;
      p2y_ff     <= p2y_in;
      ay_ff      <= ay_in;
      flags_a_ff <= flags_a_in;
      flags_b_ff <= flags_b_in;
   end

endmodule

// ----- hdl/ftsw_fifo.sv -----
// short job queue between front end and span walker
module ftsw_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  ftsw_pkg::job_type push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output ftsw_pkg::job_type pop_job
);
   import ftsw_pkg::*;

   job_type                 slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0] count_ff, count_in;
   logic                     push, pop;

   function automatic logic [FIFO_PTR_BITS-1:0] ptr_next(logic [FIFO_PTR_BITS-1:0] p);
      return (p == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_PTR_BITS'(1);
   endfunction

   assign push_ready = (count_ff != FIFO_CNT_BITS'(FIFO_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + FIFO_CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - FIFO_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- hdl/ftsw_walk.sv -----
// back end: steps the edge accumulators row by row and emits spans
module ftsw_walk (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               job_valid,
   output logic                               job_ready,
   input  ftsw_pkg::job_type                  job,
   output logic                               busy,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ftsw_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                               rsp_tlast
);
   import ftsw_pkg::*;

   localparam logic signed [SPAN_BITS-1:0] SPAN_MAX = SPAN_BITS'(2**(COORD_BITS-1) - 1);
   localparam logic signed [SPAN_BITS-1:0] SPAN_MIN = SPAN_BITS'(-(2**(COORD_BITS-1)));

   walk_state_type state_ff, state_in;

   dir_type   dir_ff, dir_in;
   acc_type   acc_a_ff, acc_a_in, acc_b_ff, acc_b_in;
   acc_type   slope_a_ff, slope_a_in, slope_b_ff, slope_b_in;
   row_type   row_ff, row_in, end_ff, end_in;

   logic                out_valid_ff, out_valid_in;
   logic [ROW_BITS-1:0] out_row_ff, out_row_in;
   coord_type           out_xa_ff, out_xa_in, out_xb_ff, out_xb_in;
   logic                out_last_ff, out_last_in;

   logic on_screen, out_free, advance, emit, finish, load;

   function automatic acc_type sat_step(acc_type acc, acc_type slope, dir_type dir);
      logic signed [ACC_BITS:0] wide;
      acc_type res;
      if (dir == DIR_DOWN) begin
         wide = {acc[ACC_BITS-1], acc} - {slope[ACC_BITS-1], slope};
      end else begin
         wide = {acc[ACC_BITS-1], acc} + {slope[ACC_BITS-1], slope};
      end
      if (wide[ACC_BITS] != wide[ACC_BITS-1]) begin
         res = wide[ACC_BITS] ? ACC_MIN : ACC_MAX;
      end else begin
         res = wide[ACC_BITS-1:0];
      end
      return res;
   endfunction

   // integer part rounded toward zero, then clipped to the coordinate range
   function automatic coord_type span_x(acc_type acc);
      logic signed [SPAN_BITS-1:0] q;
      logic                        round_up;
      coord_type                   res;
      round_up = acc[ACC_BITS-1] && (acc[FRAC_BITS-1:0] != '0);
      q = $signed(acc[ACC_BITS-1:FRAC_BITS]) + $signed({{(SPAN_BITS-1){1'b0}}, round_up});
      if (q > SPAN_MAX) begin
         res = SPAN_MAX[COORD_BITS-1:0];
      end else if (q < SPAN_MIN) begin
         res = SPAN_MIN[COORD_BITS-1:0];
      end else begin
         res = q[COORD_BITS-1:0];
      end
      return res;
   endfunction

   function automatic acc_type start_acc(coord_type x);
      return {{(ACC_BITS-COORD_BITS-FRAC_BITS){x[COORD_BITS-1]}}, x, {FRAC_BITS{1'b0}}};
   endfunction

   assign on_screen = (row_ff >= ROW_ZERO) && (row_ff <= ROW_LAST);
   assign out_free  = !out_valid_ff || rsp_tready;
   assign advance   = (state_ff == WALK_RUN) && (!on_screen || out_free);
   assign emit      = advance && on_screen;
   assign finish    = emit && (row_ff == end_ff);
   assign load      = job_valid && job_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         WALK_IDLE: if (job_valid) state_in = WALK_RUN;
         WALK_RUN:  if (finish) state_in = WALK_IDLE;
         default:   state_in = WALK_IDLE;
      endcase
   end

   always_comb begin
      job_ready = (state_ff == WALK_IDLE);
      busy      = (state_ff == WALK_RUN);
   end

   always_comb begin
      dir_in     = dir_ff;
      acc_a_in   = acc_a_ff;
      acc_b_in   = acc_b_ff;
      slope_a_in = slope_a_ff;
      slope_b_in = slope_b_ff;
      row_in     = row_ff;
      end_in     = end_ff;
      if (load) begin
         dir_in     = job.dir;
         acc_a_in   = start_acc(job.start_x_a);
         acc_b_in   = start_acc(job.start_x_b);
         slope_a_in = job.slope_a;
         slope_b_in = job.slope_b;
         row_in     = job.start_row;
         end_in     = job.end_row;
      end else if (advance) begin
         acc_a_in = sat_step(acc_a_ff, slope_a_ff, dir_ff);
         acc_b_in = sat_step(acc_b_ff, slope_b_ff, dir_ff);
         row_in   = (dir_ff == DIR_DOWN) ? row_ff - ROW_ONE : row_ff + ROW_ONE;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_row_in   = out_row_ff;
      out_xa_in    = out_xa_ff;
      out_xb_in    = out_xb_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_row_in   = row_ff[ROW_BITS-1:0];
         out_xa_in    = span_x(acc_a_ff);
         out_xb_in    = span_x(acc_b_ff);
         out_last_in  = finish;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= WALK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dir_ff      <= dir_in;
      acc_a_ff    <= acc_a_in;
      acc_b_ff    <= acc_b_in;
      slope_a_ff  <= slope_a_in;
      slope_b_ff  <= slope_b_in;
      row_ff      <= row_in;
      end_ff      <= end_in;
      out_row_ff  <= out_row_in;
      out_xa_ff   <= out_xa_in;
      out_xb_ff   <= out_xb_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({out_xb_ff, out_xa_ff, out_row_ff});
   assign rsp_tlast  = out_last_ff;

endmodule

// ----- hdl/flat_triangle_span_walker_unit.sv -----
// top level of the flat triangle span walker
// Takes one flat-edged triangle per request transaction and returns one span
// transaction per walked row that lies on screen, the final one with tlast set.
// The front end takes the request, runs two parallel bit-serial dividers for
// the NUM_BITS (26) bit edge slopes, sees them finish and hands the job over,
// and takes no new request before then. A two-entry job queue lets the front
// end divide for the next triangle while the walker runs.
// The walker loads a job and then steps one row per cycle, holding on an
// on-screen row while its output register is full and not taken, from the
// start row to the last on-screen row (off-screen rows are stepped without
// output): 64 rows for a triangle that crosses the whole screen, up to 576
// when the start row lies at the far end of the coordinate range. One span per
// cycle leaves through the output register while the sink keeps tready high.
// Triangles with no on-screen rows produce no transaction at all.
module flat_triangle_span_walker_unit (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // apex_x, apex_y, edge_a_x, edge_a_y, edge_b_x, edge_b_y, zero pad
   input  logic [ftsw_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // req_type: walk direction, 0 rows increasing, 1 rows decreasing
   input  logic                               req_tuser,
   // span channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // span_row, span_x_first, span_x_second, zero pad
   output logic [ftsw_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // last span of the triangle
   output logic                               rsp_tlast
);
   import ftsw_pkg::*;

   // front end to queue
   logic    push_valid, push_ready;
   job_type push_job;

   // queue to walker
   logic    pop_valid, pop_ready;
   job_type pop_job;

   logic    walk_busy;

   // slope division and row range classification
   ftsw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .job_valid  (push_valid),
      .job_ready  (push_ready),
      .job        (push_job)
   );

   // decouples the dividers from the row walk
   ftsw_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   // row walk with saturating accumulators and the registered span output
   ftsw_walk u_walk (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (pop_valid),
      .job_ready  (pop_ready),
      .job        (pop_job),
      .busy       (walk_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef NO_ASSERTIONS
   // a taken request occupies the front end for its divide
   a_front_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("front end ready right after taking a request");

   // a job leaving the queue starts the walker
   a_walk_starts_on_pop: assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready) |=> walk_busy)
      else $error("walker idle after taking a job");

   // reset leaves no span pending and no walk in progress
   a_clean_after_reset: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_tvalid && !walk_busy))
      else $error("span or walk pending after reset");
`endif

endmodule
